// ===== sv/mcg_pkg.sv =====
// Shared constants for the midpoint circle generator.
`timescale 1ns / 1ps

package mcg_pkg;

   // Default coordinate width of center and radius.
   localparam int COORD_BITS_DEF = 11;

   // Input command codes.
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // Point index within one group of eight symmetric points.
   localparam logic [2:0] LAST_POINT_IDX = 3'd7;

endpackage

// ===== sv/mcg_if.sv =====
// Valid/ready channel interfaces for command items and point items.
`timescale 1ns / 1ps

interface mcg_req_if import mcg_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic                  command;
   logic [COORD_BITS-1:0] center_x;
   logic [COORD_BITS-1:0] center_y;
   logic [COORD_BITS-1:0] radius;

   modport source (output valid, command, center_x, center_y, radius, input ready);
   modport sink   (input valid, command, center_x, center_y, radius, output ready);
endinterface

interface mcg_rsp_if import mcg_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS+1:0] point_x;
   logic signed [COORD_BITS+1:0] point_y;
   logic                         point_valid;
   logic                         last;
   logic                         circle_done;

   modport source (output valid, point_x, point_y, point_valid, last, circle_done,
                   input ready);
   modport sink   (input valid, point_x, point_y, point_valid, last, circle_done,
                   output ready);
endinterface

// ===== sv/mcg_front.sv =====
// Front end: accepts command items, runs the midpoint decision update, emits jobs.
`timescale 1ns / 1ps

module mcg_front import mcg_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int JOB_BITS  = 4 * COORD_BITS + 3
) (
   input  logic                clock,
   input  logic                reset,
   mcg_req_if.sink             req_bus,
   output logic                job_push,
   output logic [JOB_BITS-1:0] job_data,
   input  logic                job_full
);

   localparam int DB = COORD_BITS + 5;

   logic [COORD_BITS-1:0]        pos_x_ff, pos_x_in;
   logic signed [COORD_BITS:0]   pos_y_ff, pos_y_in;
   logic signed [DB-1:0]         dec_ff, dec_in;
   logic [COORD_BITS-1:0]        cx_ff, cx_in;
   logic [COORD_BITS-1:0]        cy_ff, cy_in;
   logic                         active_ff, active_in;

   logic                         accept;
   logic signed [COORD_BITS+1:0] diff;
   logic signed [DB-1:0]         dec_lo;
   logic signed [DB-1:0]         dec_hi;
   logic [COORD_BITS-1:0]        x_next;
   logic signed [COORD_BITS:0]   y_next;
   logic                         done;
   logic                         job_pv;
   logic                         job_done;

   assign req_bus.ready = !job_full;
   assign accept        = req_bus.valid && !job_full;
   assign job_push      = accept;

   // Decision update for both branches
   assign diff   = $signed({2'b00, pos_x_ff}) - $signed({pos_y_ff[COORD_BITS], pos_y_ff});
   assign dec_lo = dec_ff + $signed(DB'({pos_x_ff, 2'b00})) + $signed(DB'(6));
   assign dec_hi = dec_ff + $signed({diff[COORD_BITS+1], diff, 2'b00}) + $signed(DB'(10));
   assign x_next = pos_x_ff + COORD_BITS'(1);

   // Advance state on each accepted item
   always_comb begin
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      dec_in    = dec_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      active_in = active_ff;
      y_next    = pos_y_ff;
      done      = 1'b0;
      job_pv    = 1'b0;
      job_done  = 1'b0;
      if (req_bus.command == CMD_START) begin
         cx_in     = req_bus.center_x;
         cy_in     = req_bus.center_y;
         pos_x_in  = '0;
         pos_y_in  = $signed({1'b0, req_bus.radius});
         dec_in    = $signed(DB'(3)) - $signed(DB'({req_bus.radius, 1'b0}));
         active_in = 1'b1;
         job_pv    = 1'b1;
      end else if (active_ff) begin
         if (dec_ff[DB-1] || dec_ff == '0) begin
            dec_in = dec_lo;
         end else begin
            dec_in = dec_hi;
            y_next = pos_y_ff - $signed((COORD_BITS + 1)'(1));
         end
         done      = $signed({1'b0, x_next}) > y_next;
         pos_x_in  = x_next;
         pos_y_in  = y_next;
         active_in = !done;
         job_pv    = 1'b1;
         job_done  = done;
      end
   end

   assign job_data = {job_pv, job_done, cy_in, cx_in, pos_y_in, pos_x_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
         dec_ff    <= '0;
         cx_ff     <= '0;
         cy_ff     <= '0;
         active_ff <= 1'b0;
      end else if (accept) begin
         pos_x_ff  <= pos_x_in;
         pos_y_ff  <= pos_y_in;
         dec_ff    <= dec_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         active_ff <= active_in;
      end
   end

endmodule

// ===== sv/mcg_queue.sv =====
// Two-entry job queue between front end and point emitter.
`timescale 1ns / 1ps

module mcg_queue #(
   parameter int DATA_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output logic [DATA_BITS-1:0] head_data
);

   logic [DATA_BITS-1:0] slot_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_data  = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != 2'd0) else $error("queue popped while empty");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != 2'd2) else $error("queue pushed while full");
`endif

endmodule

// ===== sv/mcg_back.sv =====
// Back end: expands jobs into symmetric points, one item per cycle while ready.
`timescale 1ns / 1ps

module mcg_back import mcg_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int JOB_BITS  = 4 * COORD_BITS + 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   input  logic [JOB_BITS-1:0] job_data,
   output logic                job_pop,
   mcg_rsp_if.source           rsp_bus
);

   localparam int PW = COORD_BITS + 2;

   logic [COORD_BITS-1:0]      job_x;
   logic signed [COORD_BITS:0] job_y;
   logic [COORD_BITS-1:0]      job_cx;
   logic [COORD_BITS-1:0]      job_cy;
   logic                       job_done;
   logic                       job_pv;

   logic [2:0]                 idx_ff, idx_in;
   logic                       load;
   logic signed [PW-1:0]       xe, ye, a_sel, b_sel, a_val, b_val;
   logic signed [PW:0]         sum_x, sum_y;

   logic                       rsp_valid_ff;
   logic signed [PW-1:0]       point_x_ff, point_x_in;
   logic signed [PW-1:0]       point_y_ff, point_y_in;
   logic                       pv_ff, pv_in;
   logic                       last_ff, last_in;
   logic                       done_ff, done_in;

   assign {job_pv, job_done, job_cy, job_cx, job_y, job_x} = job_data;

   // Take a point when the output register is free or being drained
   assign load    = job_valid && (!rsp_valid_ff || rsp_bus.ready);
   assign job_pop = load && (!job_pv || idx_ff == LAST_POINT_IDX);
   assign idx_in  = job_pop ? 3'd0 : idx_ff + 3'd1;

   // Pick octant: bit 2 swaps, bit 0 negates first, bit 1 negates second
   assign xe    = $signed({2'b00, job_x});
   assign ye    = $signed({job_y[COORD_BITS], job_y});
   assign a_sel = idx_ff[2] ? ye : xe;
   assign b_sel = idx_ff[2] ? xe : ye;
   assign a_val = idx_ff[0] ? -a_sel : a_sel;
   assign b_val = idx_ff[1] ? -b_sel : b_sel;
   assign sum_x = {a_val[PW-1], a_val} + $signed({3'b000, job_cx});
   assign sum_y = {b_val[PW-1], b_val} + $signed({3'b000, job_cy});

   always_comb begin
      if (job_pv) begin
         point_x_in = sum_x[PW-1:0];
         point_y_in = sum_y[PW-1:0];
         pv_in      = 1'b1;
         last_in    = idx_ff == LAST_POINT_IDX;
         done_in    = job_done;
      end else begin
         point_x_in = '0;
         point_y_in = '0;
         pv_in      = 1'b0;
         last_in    = 1'b1;
         done_in    = 1'b0;
      end
   end

   // Hold control: output valid and point index
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            idx_ff       <= idx_in;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      if (load) begin
         point_x_ff <= point_x_in;
         point_y_ff <= point_y_in;
         pv_ff      <= pv_in;
         last_ff    <= last_in;
         done_ff    <= done_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.point_x     = point_x_ff;
   assign rsp_bus.point_y     = point_y_ff;
   assign rsp_bus.point_valid = pv_ff;
   assign rsp_bus.last        = last_ff;
   assign rsp_bus.circle_done = done_ff;

`ifndef SYNTHESIS
   a_mid_run_job: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 3'd0 |-> job_valid && job_pv) else $error("point run lost its job");
   a_reset_idle: assert property (@(posedge clock)
      reset |=> idx_ff == 3'd0 && !rsp_valid_ff) else $error("emitter not idle after reset");
`endif

endmodule

// ===== sv/midpoint_circle_generator_unit.sv =====
// Top level of the midpoint circle generator.
`timescale 1ns / 1ps
//
// Usage:
//   req_bus carries command items: command 0 starts a circle from center_x,
//   center_y and radius; command 1 advances one step along the octant.
//   rsp_bus carries point items: point_x/point_y (two's complement, center
//   offset), point_valid, last on the final point of a command, and
//   circle_done on every point of the step after which x passes y.
//   A start or an active step gives eight points; a step with no circle in
//   progress gives one item with point_valid low and last high.
// Timing:
//   With the emitter idle, an accepted command is first written into the job
//   queue; its first point is then registered into the output register on rsp_bus.
//   The point emitter issues one point per cycle while the receiver holds ready
//   high, so a sustained stream of commands is limited by the emitter's single
//   output port. A two-entry job queue lets commands be accepted
//   while earlier points are still draining.
// Reset and stall:
//   Synchronous reset empties the queue, drops any pending point and clears
//   the circle state to idle. When the receiver holds ready low the output
//   register holds its point, the queue fills, and req_bus.ready falls.

module midpoint_circle_generator_unit import mcg_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   mcg_req_if.sink   req_bus,
   mcg_rsp_if.source rsp_bus
);

   localparam int JOB_BITS = 4 * COORD_BITS + 3;

   logic                job_push;
   logic [JOB_BITS-1:0] job_in_data;
   logic                job_full;
   logic                job_pop;
   logic                job_valid;
   logic [JOB_BITS-1:0] job_out_data;

   // Accept and classify commands
   mcg_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .job_push (job_push),
      .job_data (job_in_data),
      .job_full (job_full)
   );

   // Decouple front end from emitter
   mcg_queue #(.DATA_BITS(JOB_BITS)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  (job_in_data),
      .full       (job_full),
      .pop        (job_pop),
      .head_valid (job_valid),
      .head_data  (job_out_data)
   );

   // Expand jobs into points
   mcg_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (job_out_data),
      .job_pop   (job_pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== tb/tb_midpoint_circle_generator_unit.sv =====
// Self-checking testbench for the midpoint circle generator: directed and random command items.
`timescale 1ns / 1ps

module tb_midpoint_circle_generator_unit;
   import mcg_pkg::*;

   localparam int            CB           = COORD_BITS_DEF;
   localparam int            OB           = CB + 2;
   localparam int            DB           = CB + 5;
   localparam int            COORD_MAX    = (1 << CB) - 1;
   localparam logic [CB-1:0] COORD_TOP    = CB'(COORD_MAX);
   localparam int            RANDOM_ITEMS = 430;
   localparam int            DRAIN_CYCLES = 16;
   localparam int            CYCLE_LIMIT  = 300_000;

   typedef struct {
      logic [OB-1:0] point_x;
      logic [OB-1:0] point_y;
      logic          point_valid;
      logic          last;
      logic          circle_done;
   } point_type;

   typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_PERIODIC, RDY_SPARSE} ready_mode_type;

   logic clock = 1'b0;
   logic reset;

   mcg_req_if #(.COORD_BITS(CB)) req_bus ();
   mcg_rsp_if #(.COORD_BITS(CB)) rsp_bus ();

   midpoint_circle_generator_unit #(.COORD_BITS(CB)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Shadow of the rasterizer state
   logic [CB-1:0]        pos_x;
   int                   pos_y;
   logic signed [DB-1:0] decision;
   logic [CB-1:0]        ctr_x;
   logic [CB-1:0]        ctr_y;
   bit                   circle_active;

   point_type      expected_points[$];
   int             error_count  = 0;
   int             items_sent   = 0;
   int             burst_left   = 0;
   int             cycle_count  = 0;
   int             stall_span   = 0;
   int             stall_tick   = 0;
   ready_mode_type stall_mode   = RDY_ALWAYS;

   always #1 clock = ~clock;

   // Queue one point, offset by the held center and wrapped to the output width
   function automatic void push_point(int k, int px, int py, bit done);
      point_type p;
      int        sx;
      int        sy;
      sx = px + int'(ctr_x);
      sy = py + int'(ctr_y);
      p.point_x     = sx[OB-1:0];
      p.point_y     = sy[OB-1:0];
      p.point_valid = 1'b1;
      p.last        = (k == LAST_POINT_IDX);
      p.circle_done = done;
      expected_points.push_back(p);
   endfunction

   // Queue the eight symmetric points of the current position
   function automatic void push_octants(bit done);
      int x;
      int y;
      x = int'(pos_x);
      y = pos_y;
      push_point(0, x, y, done);
      push_point(1, -x, y, done);
      push_point(2, x, -y, done);
      push_point(3, -x, -y, done);
      push_point(4, y, x, done);
      push_point(5, -y, x, done);
      push_point(6, y, -x, done);
      push_point(7, -y, -x, done);
   endfunction

   // Advance the shadow state by one accepted command and queue its points
   function automatic void predict_points(logic cmd, logic [CB-1:0] cx, logic [CB-1:0] cy,
                                          logic [CB-1:0] r);
      int        nd;
      bit        done;
      point_type p;
      if (cmd == CMD_START) begin
         ctr_x         = cx;
         ctr_y         = cy;
         pos_x         = '0;
         pos_y         = int'(r);
         nd            = 3 - 2 * int'(r);
         decision      = nd[DB-1:0];
         circle_active = 1'b1;
         push_octants(1'b0);
      end else if (!circle_active) begin
         // step with no circle in progress: one empty point
         p.point_x     = '0;
         p.point_y     = '0;
         p.point_valid = 1'b0;
         p.last        = 1'b1;
         p.circle_done = 1'b0;
         expected_points.push_back(p);
      end else begin
         if (decision <= 0) begin
            nd = int'(decision) + 4 * int'(pos_x) + 6;
         end else begin
            nd    = int'(decision) + 4 * (int'(pos_x) - pos_y) + 10;
            pos_y = pos_y - 1;
         end
         decision = nd[DB-1:0];
         pos_x    = pos_x + 1'b1;
         done     = int'(pos_x) > pos_y;
         if (done) begin
            circle_active = 1'b0;
         end
         push_octants(done);
      end
   endfunction

   function automatic void check_field(string name, logic [OB-1:0] want, logic [OB-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Compare each accepted point with the oldest expectation
   always @(posedge clock) begin : point_checker
      point_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_points.size() == 0) begin
            $error("unexpected point item: x %0d y %0d", rsp_bus.point_x, rsp_bus.point_y);
            error_count++;
         end else begin
            want = expected_points.pop_front();
            check_field("point_x", want.point_x, rsp_bus.point_x);
            check_field("point_y", want.point_y, rsp_bus.point_y);
            check_field("point_valid", OB'(want.point_valid), OB'(rsp_bus.point_valid));
            check_field("last", OB'(want.last), OB'(rsp_bus.last));
            check_field("circle_done", OB'(want.circle_done), OB'(rsp_bus.circle_done));
         end
      end
   end

   // Stall the receiver in spans, each with a pattern of its own
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode = ready_mode_type'($urandom_range(0, 3));
         stall_span = $urandom_range(8, 80);
      end
      stall_span--;
      stall_tick++;
      case (stall_mode)
         RDY_ALWAYS:   rsp_bus.ready <= 1'b1;
         RDY_COIN:     rsp_bus.ready <= ($urandom_range(0, 1) == 1);
         RDY_PERIODIC: rsp_bus.ready <= (stall_tick % 4 == 0);
         default:      rsp_bus.ready <= ($urandom_range(0, 11) == 0);
      endcase
   end

   // Drop the run if it hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Present one item, hold it until accepted, then predict its points
   task automatic send_item(logic cmd, logic [CB-1:0] cx, logic [CB-1:0] cy,
                            logic [CB-1:0] r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid    <= 1'b1;
      req_bus.command  <= cmd;
      req_bus.center_x <= cx;
      req_bus.center_y <= cy;
      req_bus.radius   <= r;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_points(cmd, cx, cy, r);
      items_sent++;
   endtask

   function automatic logic [CB-1:0] rand_coord();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return COORD_TOP;
         default: return CB'($urandom_range(0, COORD_MAX));
      endcase
   endfunction

   // Mostly small circles so that most of them run to completion
   function automatic logic [CB-1:0] pick_radius();
      if ($urandom_range(0, 4) == 0) begin
         return CB'($urandom_range(25, 80));
      end
      return CB'($urandom_range(0, 24));
   endfunction

   // Step the current circle until it completes or max_steps have gone
   task automatic run_steps(int max_steps);
      int n;
      n = 0;
      while (circle_active && n < max_steps) begin
         send_item(CMD_STEP, rand_coord(), rand_coord(), rand_coord());
         n++;
      end
   endtask

   task automatic test_idle_step();
      send_item(CMD_STEP, COORD_TOP, COORD_TOP, COORD_TOP);
   endtask

   // Zero radius: first step drops y below zero and finishes the circle
   task automatic test_zero_radius();
      send_item(CMD_START, '0, '0, '0);
      send_item(CMD_STEP, '0, '0, '0);
      send_item(CMD_STEP, '0, '0, '0);
      send_item(CMD_START, COORD_TOP, COORD_TOP, '0);
      send_item(CMD_STEP, COORD_TOP, COORD_TOP, COORD_TOP);
   endtask

   // Largest radius at both corners, so points reach past both ends of the coordinate range
   task automatic test_extreme_circles();
      send_item(CMD_START, COORD_TOP, COORD_TOP, COORD_TOP);
      run_steps(3);
      send_item(CMD_START, '0, '0, COORD_TOP);
      run_steps(2);
   endtask

   // Abandon a circle midway with a new start, then finish the new one
   task automatic test_restart_while_active();
      send_item(CMD_START, 11'd1000, 11'd500, 11'd5);
      run_steps(2);
      send_item(CMD_START, 11'd7, 11'd9, 11'd3);
      run_steps(COORD_MAX);
   endtask

   task automatic test_unit_circle();
      send_item(CMD_START, 11'd1024, 11'd1024, 11'd1);
      run_steps(COORD_MAX);
      send_item(CMD_STEP, 11'd1024, 11'd1024, 11'd1);
   endtask

   // Mostly complete circles, with abandoned, large and noise items mixed in
   task automatic test_random_circles();
      int target;
      int choice;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         choice = $urandom_range(0, 19);
         if (choice < 14) begin
            send_item(CMD_START, rand_coord(), rand_coord(), pick_radius());
            if ($urandom_range(0, 5) == 0) begin
               run_steps($urandom_range(0, 4));
            end else begin
               run_steps(2 * COORD_MAX);
            end
            if ($urandom_range(0, 2) == 0) begin
               send_item(CMD_STEP, rand_coord(), rand_coord(), rand_coord());
            end
         end else if (choice < 16) begin
            send_item(CMD_START, rand_coord(), rand_coord(),
                      CB'($urandom_range(COORD_MAX / 2, COORD_MAX)));
            run_steps($urandom_range(1, 6));
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_item(1'($urandom_range(0, 1)), CB'($urandom_range(0, COORD_MAX)),
                         CB'($urandom_range(0, COORD_MAX)),
                         CB'($urandom_range(0, COORD_MAX)));
            end
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.command  = CMD_START;
      req_bus.center_x = '0;
      req_bus.center_y = '0;
      req_bus.radius   = '0;
      rsp_bus.ready    = 1'b0;
      pos_x            = '0;
      pos_y            = 0;
      decision         = '0;
      ctr_x            = '0;
      ctr_y            = '0;
      circle_active    = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_idle_step();
      test_zero_radius();
      test_extreme_circles();
      test_restart_while_active();
      test_unit_circle();
      test_random_circles();

      // Drain the outstanding points, then watch for strays
      req_bus.valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
